// ===== rtl/core/sges_pkg.sv =====
// ----------------------------------------------------------------------------
// sges_pkg: shared types and constants of the softened gravity Euler step
// Register indexes, command codes, reset values, sequencer states and the
// 48-bit saturation helper.
// ----------------------------------------------------------------------------
package sges_pkg;

  // fixed field widths
  localparam int unsigned QW        = 48;  // position, velocity, acceleration
  localparam int unsigned MASS_W    = 40;
  localparam int unsigned DIST_W    = 32;  // Q16.16 distances
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned MAG_W     = QW - 1;

  localparam int unsigned FRAC_BITS_DEF = 32;

  localparam logic [DIST_W-1:0] MIN_DIST_RST = 32'd2621440;  // 40.0
  localparam logic [DIST_W-1:0] SOFT_RST     = 32'd655360;   // 10.0

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_INIT_X   = 3'd0,
    REG_INIT_Y   = 3'd1,
    REG_INIT_VX  = 3'd2,
    REG_INIT_VY  = 3'd3,
    REG_MIN_DIST = 3'd4,
    REG_SOFTEN   = 3'd5
  } reg_idx_e;

  // item commands
  typedef enum logic {
    CMD_STEP    = 1'b0,
    CMD_RESTORE = 1'b1
  } cmd_e;

  // sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SQX  = 13'b0000000000010,
    S_SQY  = 13'b0000000000100,
    S_ROOT = 13'b0000000001000,
    S_DD   = 13'b0000000010000,
    S_EE   = 13'b0000000100000,
    S_GDIV = 13'b0000001000000,
    S_XMUL = 13'b0000010000000,
    S_XDIV = 13'b0000100000000,
    S_YMUL = 13'b0001000000000,
    S_YDIV = 13'b0010000000000,
    S_UPD  = 13'b0100000000000,
    S_HOLD = 13'b1000000000000
  } state_e;

  // clamp a 49-bit signed sum to 48 bits
  function automatic logic signed [QW-1:0] sat48(input logic signed [QW:0] v);
    logic signed [QW-1:0] r;
    if (v[QW] != v[QW-1]) begin
      r = v[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/softened_gravity_euler_step.sv =====
// ----------------------------------------------------------------------------
// softened_gravity_euler_step: one body under softened point-mass gravity
// Keeps position, velocity and alive flag; each step item applies one
// semi-implicit Euler step toward an attractor using one shared adder.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o | command, attractor x/y/mass/r
//  out     | output    | out_valid_o/out_stall_i | pos, vel, acc x/y, alive
//  cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
//  A step beat runs six shift-add multiplies, a square root, a divide for the
//  pull and two divides for the direction, all on one adder. A zero offset
//  skips the rest after the root. A restore beat goes straight to the update.
//  Input stalls while a beat is in work; a held result stalls the update.
//  Reset clears control and state.
// ----------------------------------------------------------------------------
module softened_gravity_euler_step #(
  parameter int unsigned FRAC_BITS = sges_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config port
  input  logic                                cfg_we_i,
  input  logic [sges_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [sges_pkg::QW-1:0]             cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic signed [sges_pkg::QW-1:0]      attractor_x_i,
  input  logic signed [sges_pkg::QW-1:0]      attractor_y_i,
  input  logic [sges_pkg::MASS_W-1:0]         attractor_mass_i,
  input  logic [sges_pkg::DIST_W-1:0]         attractor_radius_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sges_pkg::QW-1:0]      pos_x_o,
  output logic signed [sges_pkg::QW-1:0]      pos_y_o,
  output logic signed [sges_pkg::QW-1:0]      vel_x_o,
  output logic signed [sges_pkg::QW-1:0]      vel_y_o,
  output logic signed [sges_pkg::QW-1:0]      acc_x_o,
  output logic signed [sges_pkg::QW-1:0]      acc_y_o,
  output logic                                alive_o
);

  localparam int unsigned QW     = sges_pkg::QW;
  localparam int unsigned MAG_W  = sges_pkg::MAG_W;
  localparam int unsigned SH     = FRAC_BITS - 16;
  localparam int unsigned UW     = QW + 1;              // |offset| and length
  localparam int unsigned MDW    = FRAC_BITS + 16;      // scaled Q16.16 values
  localparam int unsigned DW     = (MDW > UW) ? MDW : UW;
  localparam int unsigned AW     = 2 * DW + 1;          // products and sums
  localparam int unsigned NQW    = 2 * DW + 2;          // dividend / radicand
  localparam int unsigned RW     = NQW;                 // remainder, adder
  localparam int unsigned GSTEPS = 3 * FRAC_BITS + 24;
  localparam int unsigned CMAX   = (GSTEPS > NQW) ? GSTEPS : NQW;
  localparam int unsigned CW     = $clog2(CMAX + 1);

  // configuration registers
  logic signed [QW-1:0]             init_x_q, init_y_q, init_vx_q, init_vy_q;
  logic [sges_pkg::DIST_W-1:0]      min_dist_q, soften_q;

  // body state
  logic signed [QW-1:0]             body_x_q, body_y_q, body_vx_q, body_vy_q;
  logic                             body_alive_q;

  // sequencer
  sges_pkg::state_e                 state_q, state_d;
  logic [CW-1:0]                    cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;
  sges_pkg::cmd_e                   cmd_q, cmd_d;

  // datapath
  logic [AW-1:0]                    acc_q, acc_d, ma_q, ma_d;
  logic [DW-1:0]                    mb_q, mb_d;
  logic [NQW-1:0]                   nq_q, nq_d;
  logic [RW-1:0]                    rem_q, rem_d;
  logic [DW:0]                      root_q, root_d;
  logic [MAG_W-1:0]                 quo_q, quo_d;
  logic                             ovf_q, ovf_d;
  logic [UW-1:0]                    ux_q, ux_d, uy_q, uy_d, len_q, len_d;
  logic                             sx_q, sx_d, sy_q, sy_d;
  logic [DW-1:0]                    d_q, d_d;
  logic [AW-1:0]                    den_q, den_d;
  logic [MAG_W-1:0]                 g_q, g_d;
  logic [sges_pkg::MASS_W-1:0]      mass_q, mass_d;
  logic [MDW-1:0]                   rad_q, rad_d;
  logic signed [QW-1:0]             ax_q, ax_d, ay_q, ay_d;

  // output payload
  logic signed [QW-1:0]             px_q, py_q, vx_q, vy_q, oax_q, oay_q;
  logic                             oalive_q;

  // shared adder / subtractor
  logic [RW-1:0]                    add_a, add_b;
  logic                             add_sub;
  logic [RW:0]                      add_sum;
  logic                             add_ge;

  logic                             in_acc, out_free, mul_state;
  logic signed [QW:0]               dx_w, dy_w;
  logic [MDW-1:0]                   md_w, eps_w;
  logic [MAG_W-1:0]                 mag_w;
  logic [UW-1:0]                    root_len;
  logic signed [QW-1:0]             nvx, nvy;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != sges_pkg::S_IDLE);

  assign md_w  = MDW'(min_dist_q) << SH;
  assign eps_w = MDW'(soften_q) << SH;

  assign dx_w = {attractor_x_i[QW-1], attractor_x_i} - {body_x_q[QW-1], body_x_q};
  assign dy_w = {attractor_y_i[QW-1], attractor_y_i} - {body_y_q[QW-1], body_y_q};

  assign mul_state = (state_q == sges_pkg::S_SQX) || (state_q == sges_pkg::S_SQY) ||
                     (state_q == sges_pkg::S_DD)  || (state_q == sges_pkg::S_EE)  ||
                     (state_q == sges_pkg::S_XMUL) || (state_q == sges_pkg::S_YMUL);

  // adder operand select
  always_comb begin
    add_a   = RW'(acc_q);
    add_b   = '0;
    add_sub = 1'b0;
    if (mul_state) begin
      add_b = mb_q[0] ? RW'(ma_q) : '0;
    end else if (state_q == sges_pkg::S_ROOT) begin
      add_a   = {rem_q[RW-3:0], nq_q[NQW-1 -: 2]};
      add_b   = RW'({root_q, 2'b01});
      add_sub = 1'b1;
    end else if (state_q == sges_pkg::S_GDIV) begin
      add_a   = {rem_q[RW-2:0], nq_q[NQW-1]};
      add_b   = RW'(den_q);
      add_sub = 1'b1;
    end else begin
      add_a   = {rem_q[RW-2:0], nq_q[NQW-1]};
      add_b   = RW'(len_q);
      add_sub = 1'b1;
    end
  end

  assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} +
                   {{RW{1'b0}}, add_sub};
  assign add_ge  = add_sum[RW];

  // root and quotient step results
  assign root_len = root_d[UW-1:0];
  assign mag_w    = ovf_d ? sges_pkg::MAG_MAX : quo_d;

  // velocity update of a step
  assign nvx = sges_pkg::sat48({body_vx_q[QW-1], body_vx_q} + {ax_q[QW-1], ax_q});
  assign nvy = sges_pkg::sat48({body_vy_q[QW-1], body_vy_q} + {ay_q[QW-1], ay_q});

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + CW'(1);
    out_valid_d = out_valid_q && out_stall_i;
    cmd_d       = cmd_q;
    acc_d       = acc_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    nq_d        = nq_q;
    rem_d       = rem_q;
    root_d      = root_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    len_d       = len_q;
    d_d         = d_q;
    den_d       = den_q;
    g_d         = g_q;
    mass_d      = mass_q;
    rad_d       = rad_q;
    ax_d        = ax_q;
    ay_d        = ay_q;

    // per-state unit step
    if (mul_state) begin
      acc_d = add_sum[AW-1:0];
      ma_d  = ma_q << 1;
      mb_d  = mb_q >> 1;
    end else if (state_q == sges_pkg::S_ROOT) begin
      rem_d  = add_ge ? add_sum[RW-1:0] : add_a;
      root_d = {root_q[DW-1:0], add_ge};
      nq_d   = nq_q << 2;
    end else if (state_q == sges_pkg::S_GDIV || state_q == sges_pkg::S_XDIV ||
                 state_q == sges_pkg::S_YDIV) begin
      rem_d = add_ge ? add_sum[RW-1:0] : add_a;
      ovf_d = ovf_q | quo_q[MAG_W-1];
      quo_d = {quo_q[MAG_W-2:0], add_ge};
      nq_d  = nq_q << 1;
    end

    case (state_q)
      sges_pkg::S_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          cmd_d  = sges_pkg::cmd_e'(command_i);
          ax_d   = '0;
          ay_d   = '0;
          sx_d   = dx_w[QW];
          sy_d   = dy_w[QW];
          ux_d   = dx_w[QW] ? UW'(-dx_w) : UW'(dx_w);
          uy_d   = dy_w[QW] ? UW'(-dy_w) : UW'(dy_w);
          mass_d = attractor_mass_i;
          rad_d  = MDW'(attractor_radius_i) << SH;
          acc_d  = '0;
          ma_d   = AW'(dx_w[QW] ? UW'(-dx_w) : UW'(dx_w));
          mb_d   = DW'(dx_w[QW] ? UW'(-dx_w) : UW'(dx_w));
          if (command_i == sges_pkg::CMD_RESTORE) begin
            state_d = sges_pkg::S_UPD;
          end else begin
            state_d = sges_pkg::S_SQX;
          end
        end
      end
      sges_pkg::S_SQX: begin
        if (cnt_q == CW'(DW - 1)) begin
          cnt_d   = '0;
          ma_d    = AW'(uy_q);
          mb_d    = DW'(uy_q);
          state_d = sges_pkg::S_SQY;
        end
      end
      sges_pkg::S_SQY: begin
        if (cnt_q == CW'(DW - 1)) begin
          cnt_d   = '0;
          nq_d    = NQW'(add_sum[AW-1:0]);
          rem_d   = '0;
          root_d  = '0;
          state_d = sges_pkg::S_ROOT;
        end
      end
      sges_pkg::S_ROOT: begin
        if (cnt_q == CW'(DW)) begin
          cnt_d = '0;
          len_d = root_len;
          d_d   = (DW'(root_len) > DW'(md_w)) ? DW'(root_len) : DW'(md_w);
          acc_d = '0;
          ma_d  = AW'((DW'(root_len) > DW'(md_w)) ? DW'(root_len) : DW'(md_w));
          mb_d  = (DW'(root_len) > DW'(md_w)) ? DW'(root_len) : DW'(md_w);
          if (root_len == '0) begin
            state_d = sges_pkg::S_UPD;
          end else begin
            state_d = sges_pkg::S_DD;
          end
        end
      end
      sges_pkg::S_DD: begin
        if (cnt_q == CW'(DW - 1)) begin
          cnt_d   = '0;
          ma_d    = AW'(eps_w);
          mb_d    = DW'(eps_w);
          state_d = sges_pkg::S_EE;
        end
      end
      sges_pkg::S_EE: begin
        if (cnt_q == CW'(DW - 1)) begin
          cnt_d   = '0;
          den_d   = add_sum[AW-1:0];
          nq_d    = {mass_q, {(NQW - sges_pkg::MASS_W){1'b0}}};
          rem_d   = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
          state_d = sges_pkg::S_GDIV;
        end
      end
      sges_pkg::S_GDIV: begin
        if (cnt_q == CW'(GSTEPS - 1)) begin
          cnt_d   = '0;
          g_d     = mag_w;
          acc_d   = '0;
          ma_d    = AW'(ux_q);
          mb_d    = DW'(mag_w);
          state_d = sges_pkg::S_XMUL;
        end
      end
      sges_pkg::S_XMUL: begin
        if (cnt_q == CW'(DW - 1)) begin
          cnt_d   = '0;
          nq_d    = NQW'(add_sum[AW-1:0]);
          rem_d   = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
          state_d = sges_pkg::S_XDIV;
        end
      end
      sges_pkg::S_XDIV: begin
        if (cnt_q == CW'(NQW - 1)) begin
          cnt_d   = '0;
          ax_d    = sx_q ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
          acc_d   = '0;
          ma_d    = AW'(uy_q);
          mb_d    = DW'(g_q);
          state_d = sges_pkg::S_YMUL;
        end
      end
      sges_pkg::S_YMUL: begin
        if (cnt_q == CW'(DW - 1)) begin
          cnt_d   = '0;
          nq_d    = NQW'(add_sum[AW-1:0]);
          rem_d   = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
          state_d = sges_pkg::S_YDIV;
        end
      end
      sges_pkg::S_YDIV: begin
        if (cnt_q == CW'(NQW - 1)) begin
          cnt_d   = '0;
          ay_d    = sy_q ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
          state_d = sges_pkg::S_UPD;
        end
      end
      sges_pkg::S_UPD: begin
        cnt_d = '0;
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = sges_pkg::S_IDLE;
        end
      end
      default: begin
        cnt_d   = '0;
        state_d = sges_pkg::S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sges_pkg::S_IDLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      cmd_q        <= sges_pkg::CMD_STEP;
      init_x_q     <= '0;
      init_y_q     <= '0;
      init_vx_q    <= '0;
      init_vy_q    <= '0;
      min_dist_q   <= sges_pkg::MIN_DIST_RST;
      soften_q     <= sges_pkg::SOFT_RST;
      body_x_q     <= '0;
      body_y_q     <= '0;
      body_vx_q    <= '0;
      body_vy_q    <= '0;
      body_alive_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
      // config writes, unknown index ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sges_pkg::REG_INIT_X:   init_x_q   <= cfg_wdata_i;
          sges_pkg::REG_INIT_Y:   init_y_q   <= cfg_wdata_i;
          sges_pkg::REG_INIT_VX:  init_vx_q  <= cfg_wdata_i;
          sges_pkg::REG_INIT_VY:  init_vy_q  <= cfg_wdata_i;
          sges_pkg::REG_MIN_DIST: min_dist_q <= cfg_wdata_i[sges_pkg::DIST_W-1:0];
          sges_pkg::REG_SOFTEN:   soften_q   <= cfg_wdata_i[sges_pkg::DIST_W-1:0];
          default: begin
          end
        endcase
      end
      // body update at the end of a beat
      if (state_q == sges_pkg::S_UPD && out_free) begin
        if (cmd_q == sges_pkg::CMD_RESTORE) begin
          body_x_q  <= init_x_q;
          body_y_q  <= init_y_q;
          body_vx_q <= init_vx_q;
          body_vy_q <= init_vy_q;
        end else begin
          body_vx_q <= nvx;
          body_vy_q <= nvy;
          body_x_q  <= sges_pkg::sat48({body_x_q[QW-1], body_x_q} + {nvx[QW-1], nvx});
          body_y_q  <= sges_pkg::sat48({body_y_q[QW-1], body_y_q} + {nvy[QW-1], nvy});
          if (d_q <= DW'(rad_q)) begin
            body_alive_q <= 1'b0;
          end
        end
      end
    end
  end

  // datapath and output payload, no reset
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    nq_q   <= nq_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    ux_q   <= ux_d;
    uy_q   <= uy_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    len_q  <= len_d;
    d_q    <= d_d;
    den_q  <= den_d;
    g_q    <= g_d;
    mass_q <= mass_d;
    rad_q  <= rad_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    if (state_q == sges_pkg::S_UPD && out_free) begin
      oax_q <= ax_q;
      oay_q <= ay_q;
      if (cmd_q == sges_pkg::CMD_RESTORE) begin
        px_q     <= init_x_q;
        py_q     <= init_y_q;
        vx_q     <= init_vx_q;
        vy_q     <= init_vy_q;
        oalive_q <= body_alive_q;
      end else begin
        vx_q     <= nvx;
        vy_q     <= nvy;
        px_q     <= sges_pkg::sat48({body_x_q[QW-1], body_x_q} + {nvx[QW-1], nvx});
        py_q     <= sges_pkg::sat48({body_y_q[QW-1], body_y_q} + {nvy[QW-1], nvy});
        oalive_q <= body_alive_q && !(d_q <= DW'(rad_q));
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = px_q;
  assign pos_y_o     = py_q;
  assign vel_x_o     = vx_q;
  assign vel_y_o     = vy_q;
  assign acc_x_o     = oax_q;
  assign acc_y_o     = oay_q;
  assign alive_o     = oalive_q;

  // checks
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != sges_pkg::S_IDLE)
    else $error("accepted beat did not start the sequencer");

  a_alive_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !body_alive_q |=> !body_alive_q)
    else $error("alive flag came back without reset");

  a_finish_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sges_pkg::S_UPD && out_free) |=> out_valid_q)
    else $error("finished beat not presented");

  a_restore_zero_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sges_pkg::S_UPD && out_free && cmd_q == sges_pkg::CMD_RESTORE)
    |=> (acc_x_o == '0 && acc_y_o == '0))
    else $error("restore beat carries nonzero acceleration");

endmodule

// ===== tb/tb_softened_gravity_euler_step.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_softened_gravity_euler_step: self-checking bench for the gravity step
// A queue-fed driver offers step and restore beats under random gaps. A
// monitor stalls at random, including one long hold-off, and checks every
// result beat against a bit-exact fixed-point predictor of body motion.
// ----------------------------------------------------------------------------
module tb_softened_gravity_euler_step;

  localparam int unsigned QW      = sges_pkg::QW;
  localparam int unsigned MASS_W  = sges_pkg::MASS_W;
  localparam int unsigned DIST_W  = sges_pkg::DIST_W;
  localparam int unsigned FB      = sges_pkg::FRAC_BITS_DEF;
  localparam int unsigned SH      = FB - 16;
  localparam longint      LIMIT   = 8000000;
  localparam logic [QW-1:0] QMAX  = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] QMIN  = {1'b1, {(QW-1){1'b0}}};

  typedef struct {
    sges_pkg::cmd_e        cmd;
    logic signed [QW-1:0]  ax;
    logic signed [QW-1:0]  ay;
    logic [MASS_W-1:0]     mass;
    logic [DIST_W-1:0]     rad;
  } step_t;

  typedef struct {
    logic signed [QW-1:0] px, py, vx, vy, gx, gy;
    logic                 alive;
  } body_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sges_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [QW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = 1'b0;
  logic signed [QW-1:0] attractor_x_i = '0;
  logic signed [QW-1:0] attractor_y_i = '0;
  logic [MASS_W-1:0] attractor_mass_i = '0;
  logic [DIST_W-1:0] attractor_radius_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [QW-1:0] pos_x_o, pos_y_o, vel_x_o, vel_y_o, acc_x_o, acc_y_o;
  logic alive_o;

  softened_gravity_euler_step DUT (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and registers
  logic signed [QW-1:0] init_x, init_y, init_vx, init_vy;
  logic [DIST_W-1:0]    min_dist, soften;
  body_t                body;
  step_t                pending_steps[$];
  body_t                expected_bodies[$];
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_req = 0;
  int                   hold_seen = 0;
  int                   hold_cnt = 0;
  int                   errors = 0;
  longint               cycles = 0;

  function automatic logic signed [QW-1:0] clamp48(input logic signed [QW+1:0] v);
    if (v > $signed({2'b00, QMAX})) return QMAX;
    if (v < $signed({2'b11, QMIN})) return QMIN;
    return v[QW-1:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = 128'(c) * 128'(c);
      if (sq <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] quot_clamped(input logic [255:0] num,
                                               input logic [255:0] den);
    logic [255:0] q;
    if (den == '0) return 64'(QMAX);
    q = num / den;
    if (q > 256'(QMAX)) return 64'(QMAX);
    return q[63:0];
  endfunction

  // advance the body by one beat and return the expected result
  function automatic body_t advance_body(input step_t s);
    logic signed [QW+1:0] dx, dy, t;
    logic [63:0]  ux, uy, len, md, eps, d, g, mx, my, rad;
    logic [127:0] den;
    logic signed [QW-1:0] gx, gy;
    body_t r;
    gx = '0;
    gy = '0;
    if (s.cmd == sges_pkg::CMD_RESTORE) begin
      body.px = init_x;
      body.py = init_y;
      body.vx = init_vx;
      body.vy = init_vy;
    end else begin
      dx  = 50'(s.ax) - 50'(body.px);
      dy  = 50'(s.ay) - 50'(body.py);
      ux  = dx < 0 ? 64'(-dx) : 64'(dx);
      uy  = dy < 0 ? 64'(-dy) : 64'(dy);
      len = floor_root(128'(ux) * 128'(ux) + 128'(uy) * 128'(uy));
      md  = 64'(min_dist) << SH;
      eps = 64'(soften) << SH;
      rad = 64'(s.rad) << SH;
      d   = len > md ? len : md;
      if (len != 0) begin
        den = 128'(d) * 128'(d) + 128'(eps) * 128'(eps);
        g   = quot_clamped(256'(s.mass) << (3 * FB - 16), 256'(den));
        mx  = quot_clamped(256'(ux) * 256'(g), 256'(len));
        my  = quot_clamped(256'(uy) * 256'(g), 256'(len));
        gx  = dx < 0 ? -QW'(mx) : QW'(mx);
        gy  = dy < 0 ? -QW'(my) : QW'(my);
      end
      t = 50'(body.vx) + 50'(gx);  body.vx = clamp48(t);
      t = 50'(body.vy) + 50'(gy);  body.vy = clamp48(t);
      t = 50'(body.px) + 50'(body.vx);  body.px = clamp48(t);
      t = 50'(body.py) + 50'(body.vy);  body.py = clamp48(t);
      if (d <= rad) body.alive = 1'b0;
    end
    r    = body;
    r.gx = gx;
    r.gy = gy;
    return r;
  endfunction

  // driver: offer queued beats, record the expectation at acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        body_t nb;
        nb = advance_body('{sges_pkg::cmd_e'(command_i), attractor_x_i,
            attractor_y_i, attractor_mass_i, attractor_radius_i});
        expected_bodies = {expected_bodies, nb};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_steps.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          step_t s;
          s = pending_steps.pop_front();
          command_i          <= s.cmd;
          attractor_x_i      <= s.ax;
          attractor_y_i      <= s.ay;
          attractor_mass_i   <= s.mass;
          attractor_radius_i <= s.rad;
          in_valid_i         <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= 3000;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor: random stalls, result checks
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_bodies.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          body_t e;
          e = expected_bodies.pop_front();
          if (pos_x_o !== e.px) begin
            $error("pos_x exp %0d got %0d", e.px, pos_x_o);
            errors++;
          end
          if (pos_y_o !== e.py) begin
            $error("pos_y exp %0d got %0d", e.py, pos_y_o);
            errors++;
          end
          if (vel_x_o !== e.vx) begin
            $error("vel_x exp %0d got %0d", e.vx, vel_x_o);
            errors++;
          end
          if (vel_y_o !== e.vy) begin
            $error("vel_y exp %0d got %0d", e.vy, vel_y_o);
            errors++;
          end
          if (acc_x_o !== e.gx) begin
            $error("acc_x exp %0d got %0d", e.gx, acc_x_o);
            errors++;
          end
          if (acc_y_o !== e.gy) begin
            $error("acc_y exp %0d got %0d", e.gy, acc_y_o);
            errors++;
          end
          if (alive_o !== e.alive) begin
            $error("alive exp %0b got %0b", e.alive, alive_o);
            errors++;
          end
        end
      end
      out_stall_i <= (hold_cnt > 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input sges_pkg::reg_idx_e idx, input logic [QW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      sges_pkg::REG_INIT_X:   init_x   = val;
      sges_pkg::REG_INIT_Y:   init_y   = val;
      sges_pkg::REG_INIT_VX:  init_vx  = val;
      sges_pkg::REG_INIT_VY:  init_vy  = val;
      sges_pkg::REG_MIN_DIST: min_dist = val[DIST_W-1:0];
      sges_pkg::REG_SOFTEN:   soften   = val[DIST_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [QW-1:0] x, y, vx, vy,
                           input logic [DIST_W-1:0] md, sf);
    write_reg(sges_pkg::REG_INIT_X, x);
    write_reg(sges_pkg::REG_INIT_Y, y);
    write_reg(sges_pkg::REG_INIT_VX, vx);
    write_reg(sges_pkg::REG_INIT_VY, vy);
    write_reg(sges_pkg::REG_MIN_DIST, QW'(md));
    write_reg(sges_pkg::REG_SOFTEN, QW'(sf));
  endtask

  task automatic queue_step(input sges_pkg::cmd_e c, input logic [QW-1:0] x, y,
                            input logic [MASS_W-1:0] m, input logic [DIST_W-1:0] r);
    step_t s;
    s = '{c, x, y, m, r};
    pending_steps = {pending_steps, s};
  endtask

  function automatic logic [QW-1:0] rand_coord();
    logic [QW-1:0] v;
    v = QW'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0, 1:    return v;
      2, 3, 4: return QW'($signed(v[24:0]));
      default: return QW'($signed(v[40:0]));
    endcase
  endfunction

  // a mostly gentle random orbit, with rare restores, wild values and captures
  task automatic queue_random(input int n);
    logic [MASS_W-1:0] m;
    logic [DIST_W-1:0] r;
    for (int i = 0; i < n; i++) begin
      m = MASS_W'({$urandom, $urandom});
      m = m >> $urandom_range(0, MASS_W - 1);
      r = $urandom_range(0, 99) < 3 ? $urandom : $urandom_range(0, 2621439);
      queue_step($urandom_range(0, 99) < 6 ? sges_pkg::CMD_RESTORE : sges_pkg::CMD_STEP,
                 rand_coord(), rand_coord(), m, r);
    end
  endtask

  task automatic drain();
    while (pending_steps.size() > 0 || expected_bodies.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    init_x   = '0;
    init_y   = '0;
    init_vx  = '0;
    init_vy  = '0;
    min_dist = sges_pkg::MIN_DIST_RST;
    soften   = sges_pkg::SOFT_RST;
    body     = '{default: '0, alive: 1'b1};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero offset, extremes, restore, huge pull, capture
    send_idle_pct = 19;
    recv_idle_pct = 51;
    queue_step(sges_pkg::CMD_STEP, '0, '0, '1, '0);
    queue_step(sges_pkg::CMD_STEP, QMAX, QMAX, '0, '0);
    queue_step(sges_pkg::CMD_STEP, QMIN, QMIN, '1, '0);
    queue_step(sges_pkg::CMD_STEP, QMAX, QMIN, '1, '0);
    queue_step(sges_pkg::CMD_RESTORE, QMAX, QMIN, '1, '1);
    queue_step(sges_pkg::CMD_STEP, 48'h1_0000_0000, '0, 40'h1_0000, '0);
    queue_step(sges_pkg::CMD_STEP, '0, 48'hFFFF_0000_0000, 40'h10_0000, '0);
    queue_step(sges_pkg::CMD_STEP, 48'h28_0000_0000, 48'h1, '1, '0);
    queue_step(sges_pkg::CMD_STEP, '0, '0, '0, '0);
    queue_step(sges_pkg::CMD_RESTORE, '0, '0, '0, '0);
    queue_step(sges_pkg::CMD_STEP, 48'h5_0000_0000, 48'h5_0000_0000, '1, '1);
    queue_step(sges_pkg::CMD_STEP, QMIN, QMAX, 40'h1, 32'hFFFF_FFFF);
    drain();

    write_all(48'h64_0000_0000, -48'sh32_0000_0000, 48'h0_8000_0000, '0,
              32'd0, 32'd0);
    queue_step(sges_pkg::CMD_RESTORE, '0, '0, '0, '0);
    queue_step(sges_pkg::CMD_STEP, 48'h64_0000_0000, -48'sh32_0000_0000, '1, '0);
    queue_random(270);
    drain();

    send_idle_pct = 51;
    recv_idle_pct = 19;
    write_all(QMAX, QMIN, QMIN, QMAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_step(sges_pkg::CMD_RESTORE, '0, '0, '0, '0);
    queue_random(270);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(rand_coord(), rand_coord(), QW'($signed(20'($urandom))),
              QW'($signed(20'($urandom))), $urandom_range(0, 5000000), $urandom);
    queue_step(sges_pkg::CMD_RESTORE, '0, '0, '0, '0);
    queue_random(270);
    hold_req++;
    drain();

    write_all(QMIN, QMAX, QMAX, QMIN, sges_pkg::MIN_DIST_RST, sges_pkg::SOFT_RST);
    queue_step(sges_pkg::CMD_RESTORE, '0, '0, '0, '0);
    queue_random(270);
    drain();

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sges_pkg.sv
rtl/core/softened_gravity_euler_step.sv
tb/tb_softened_gravity_euler_step.sv
